FILE: hw/rtl/gain_clamp_rms_meter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gain clamp RMS meter
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef GAIN_CLAMP_RMS_METER_DEFINES_SVH
`define GAIN_CLAMP_RMS_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/gcrm_pkg.sv
// ---------------------------------------------------------------------------
// gcrm_pkg
// Types, microcode encoding and constants of the gain clamp RMS meter.
// ---------------------------------------------------------------------------
`default_nettype none

package gcrm_pkg;

	localparam int SUM_W   = 41;                // square accumulator, Q2.30 plus headroom
	localparam int ROOT_W  = (SUM_W + 1) / 2;   // root bits of the mean
	localparam int RAD_W   = 2 * ROOT_W;        // radicand, even width
	localparam int SREM_W  = ROOT_W + 3;        // square-root partial remainder
	localparam int SQ_W    = 31;                // square of a Q1.15 magnitude
	localparam int PC_W    = 4;
	localparam int LOOP_W  = 6;
	localparam int GAIN_W  = 16;
	localparam int LEVEL_W = 15;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'h7fff;
	localparam logic [LOOP_W-1:0]  DIV_LOOP   = LOOP_W'(SUM_W);
	localparam logic [LOOP_W-1:0]  SQRT_LOOP  = LOOP_W'(ROOT_W);

	localparam logic [0:0] REG_GAIN = 1'b0;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t STEP_WAIT      = 4'd0;
	localparam pc_t STEP_MUL       = 4'd1;
	localparam pc_t STEP_SCALE     = 4'd2;
	localparam pc_t STEP_SQUARE    = 4'd3;
	localparam pc_t STEP_ACC       = 4'd4;
	localparam pc_t STEP_DIV_INIT  = 4'd5;
	localparam pc_t STEP_DIV       = 4'd6;
	localparam pc_t STEP_SQRT_INIT = 4'd7;
	localparam pc_t STEP_SQRT      = 4'd8;
	localparam pc_t STEP_FINISH    = 4'd9;
	localparam pc_t STEP_EMIT      = 4'd10;
	localparam pc_t STEP_RETURN    = 4'd11;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_MUL,
		OP_SCALE,
		OP_SQUARE,
		OP_ACC,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_FINISH,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_NOT_LAST,
		COND_LOOP_MORE,
		COND_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		pc_t               target;
		logic              load_loop;
		logic [LOOP_W-1:0] loop_init;
	} uword_t;

	typedef struct packed {
		logic sample_valid;
		logic last;
		logic out_blocked;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gcrm_ucode_rom.sv
// ---------------------------------------------------------------------------
// gcrm_ucode_rom
// Control store: one microword per step of the per-word program.
// ---------------------------------------------------------------------------
`default_nettype none

module gcrm_ucode_rom import gcrm_pkg::*; (
	input  pc_t    pc,
	output uword_t uw
);

	always_comb begin
		uw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_WAIT, load_loop: 1'b0,
			loop_init: '0};
		case (pc)
			STEP_WAIT: begin
				uw.op     = OP_LATCH;
				uw.cond   = COND_NO_INPUT;
				uw.target = STEP_WAIT;
			end
			STEP_MUL: begin
				uw.op   = OP_MUL;
				uw.cond = COND_NEVER;
			end
			STEP_SCALE: begin
				uw.op   = OP_SCALE;
				uw.cond = COND_NEVER;
			end
			STEP_SQUARE: begin
				uw.op   = OP_SQUARE;
				uw.cond = COND_NEVER;
			end
			STEP_ACC: begin
				// plain samples skip the mean and root
				uw.op     = OP_ACC;
				uw.cond   = COND_NOT_LAST;
				uw.target = STEP_EMIT;
			end
			STEP_DIV_INIT: begin
				uw.op        = OP_DIV_INIT;
				uw.cond      = COND_NEVER;
				uw.load_loop = 1'b1;
				uw.loop_init = DIV_LOOP;
			end
			STEP_DIV: begin
				uw.op     = OP_DIV_STEP;
				uw.cond   = COND_LOOP_MORE;
				uw.target = STEP_DIV;
			end
			STEP_SQRT_INIT: begin
				uw.op        = OP_SQRT_INIT;
				uw.cond      = COND_NEVER;
				uw.load_loop = 1'b1;
				uw.loop_init = SQRT_LOOP;
			end
			STEP_SQRT: begin
				uw.op     = OP_SQRT_STEP;
				uw.cond   = COND_LOOP_MORE;
				uw.target = STEP_SQRT;
			end
			STEP_FINISH: begin
				uw.op   = OP_FINISH;
				uw.cond = COND_NEVER;
			end
			STEP_EMIT: begin
				uw.op     = OP_EMIT;
				uw.cond   = COND_OUT_BLOCKED;
				uw.target = STEP_EMIT;
			end
			STEP_RETURN: begin
				uw.op     = OP_NOP;
				uw.cond   = COND_ALWAYS;
				uw.target = STEP_WAIT;
			end
			default: begin
				uw.op     = OP_NOP;
				uw.cond   = COND_ALWAYS;
				uw.target = STEP_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gcrm_sequencer.sv
// ---------------------------------------------------------------------------
// gcrm_sequencer
// Step counter, loop counter and conditional jumps over the control store.
// ---------------------------------------------------------------------------
`default_nettype none

module gcrm_sequencer import gcrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output uword_t     uw
);

	pc_t               pc_q;
	logic [LOOP_W-1:0] loop_q;
	logic              jump;

	gcrm_ucode_rom u_rom (
		.pc (pc_q),
		.uw (uw)
	);

	always_comb begin
		case (uw.cond)
			COND_NEVER:       jump = 1'b0;
			COND_ALWAYS:      jump = 1'b1;
			COND_NO_INPUT:    jump = !status.sample_valid;
			COND_NOT_LAST:    jump = !status.last;
			COND_LOOP_MORE:   jump = (loop_q != LOOP_W'(1));
			COND_OUT_BLOCKED: jump = status.out_blocked;
			default:          jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= STEP_WAIT;
			loop_q <= '0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + pc_t'(1);
			if (uw.load_loop) begin
				loop_q <= uw.loop_init;
			end else if (uw.cond == COND_LOOP_MORE) begin
				loop_q <= loop_q - LOOP_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gcrm_datapath.sv
// ---------------------------------------------------------------------------
// gcrm_datapath
// Gain multiply, clamp, square accumulate, bit-serial divide and root,
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module gcrm_datapath import gcrm_pkg::*; #(
	parameter int CNT_W       = 11,
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  uword_t                    uw,
	input  logic [GAIN_W-1:0]         gain,
	input  logic                      sample_valid,
	input  logic signed [15:0]        pcm_sample,
	input  logic                      end_of_buffer,
	input  logic                      result_stall,
	output logic                      result_valid,
	output logic signed [15:0]        scaled_sample,
	output logic                      level_valid,
	output logic [LEVEL_W-1:0]        rms_level,
	output dp_status_t                status
);

	logic signed [15:0]   sample_q;
	logic                 last_q;
	logic signed [32:0]   prod_q;
	logic signed [15:0]   scaled_q;
	logic [15:0]          mag_q;
	logic [SQ_W-1:0]      sq_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic [RAD_W-1:0]     work_q;
	logic [CNT_W-1:0]     drem_q;
	logic [SREM_W-1:0]    srem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 out_valid_q;
	logic signed [15:0]   out_sample_q;
	logic                 out_last_q;
	logic [LEVEL_W-1:0]   out_level_q;

	logic signed [32:0]   prod_c;
	logic signed [32:0]   shr_c;
	logic signed [15:0]   sat_c;
	logic [16:0]          neg_c;
	logic [31:0]          sqw_c;
	logic [SUM_W:0]       sum_ext_c;
	logic [CNT_W:0]       dtrial_c;
	logic [CNT_W:0]       ddiff_c;
	logic                 dge_c;
	logic [SREM_W-1:0]    snum_c;
	logic [SREM_W-1:0]    stest_c;
	logic                 sge_c;
	logic                 blocked_c;

	assign prod_c = 33'(sample_q) * 33'($signed({1'b0, gain}));
	// round half up, then floor shift
	assign shr_c  = (prod_q + 33'sd2048) >>> 12;

	always_comb begin
		if (shr_c > 33'sd32767) begin
			sat_c = 16'sh7fff;
		end else if (shr_c < -33'sd32768) begin
			sat_c = 16'sh8000;
		end else begin
			sat_c = shr_c[15:0];
		end
	end

	assign neg_c     = 17'd0 - {sat_c[15], sat_c};
	assign sqw_c     = 32'(mag_q) * 32'(mag_q);
	assign sum_ext_c = {1'b0, sum_q} + (SUM_W+1)'(sq_q);

	// restoring divide, one quotient bit per step
	assign dtrial_c = {drem_q, work_q[SUM_W-1]};
	assign dge_c    = (dtrial_c >= {1'b0, count_q});
	assign ddiff_c  = dtrial_c - {1'b0, count_q};

	// digit-by-digit square root, two radicand bits per step
	assign snum_c  = {srem_q[SREM_W-3:0], work_q[RAD_W-1:RAD_W-2]};
	assign stest_c = SREM_W'({root_q, 2'b01});
	assign sge_c   = (snum_c >= stest_c);

	assign blocked_c = out_valid_q && result_stall;

	assign status.sample_valid = sample_valid;
	assign status.last         = last_q;
	assign status.out_blocked  = blocked_c;

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LATCH: begin
				if (sample_valid) begin
					sample_q <= pcm_sample;
					last_q   <= end_of_buffer;
				end
			end
			OP_MUL: begin
				prod_q <= prod_c;
			end
			OP_SCALE: begin
				scaled_q <= sat_c;
				mag_q    <= sat_c[15] ? neg_c[15:0] : sat_c;
			end
			OP_SQUARE: begin
				sq_q <= sqw_c[SQ_W-1:0];
			end
			OP_DIV_INIT: begin
				work_q <= RAD_W'(sum_q);
				drem_q <= '0;
			end
			OP_DIV_STEP: begin
				drem_q <= dge_c ? ddiff_c[CNT_W-1:0] : dtrial_c[CNT_W-1:0];
				work_q <= RAD_W'({work_q[SUM_W-2:0], dge_c});
			end
			OP_SQRT_INIT: begin
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				srem_q <= sge_c ? snum_c - stest_c : snum_c;
				root_q <= {root_q[ROOT_W-2:0], sge_c};
				work_q <= {work_q[RAD_W-3:0], 2'b00};
			end
			OP_FINISH: begin
				level_q <= (root_q > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root_q[LEVEL_W-1:0];
			end
			OP_EMIT: begin
				if (!blocked_c) begin
					out_sample_q <= scaled_q;
					out_last_q   <= last_q;
					out_level_q  <= last_q ? level_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (uw.op == OP_ACC && count_q < CNT_W'(MAX_SAMPLES)) begin
				sum_q   <= sum_ext_c[SUM_W] ? '1 : sum_ext_c[SUM_W-1:0];
				count_q <= count_q + CNT_W'(1);
			end else if (uw.op == OP_FINISH) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (uw.op == OP_EMIT && !blocked_c) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign scaled_sample = out_sample_q;
	assign level_valid   = out_last_q;
	assign rms_level     = out_level_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gain_clamp_rms_meter.sv
// ---------------------------------------------------------------------------
// gain_clamp_rms_meter
// Microphone gain stage with clamp and per-buffer RMS level meter.
// ---------------------------------------------------------------------------
// Input channel (sample_valid/sample_stall) carries one PCM word with an
// end_of_buffer flag; output channel (result_valid/result_stall) returns
// exactly one word per input: the gain-scaled, clamped sample plus, on the
// flagged word, the RMS level of the buffer.
// A microcoded sequencer steps one word at a time through a shared datapath.
// A plain word runs the latch, multiply, scale, square, accumulate, emit
// and return steps before the next acceptance, the result registered at
// emit. A flagged word adds the bit-serial divide (41 steps) and square
// root (21 steps) plus three setup steps before the emit step.
// The output register lets the next word be accepted while a result waits;
// a word reaching the emit step behind a stalled result holds there, and
// sample_stall stays high until the result register frees up.
// Reset clears the accumulator, sample count and output valid, and sets the
// gain to unity (4096). The gain is written over the APB port at offset 0.
// ---------------------------------------------------------------------------
`default_nettype none

module gain_clamp_rms_meter import gcrm_pkg::*; #(
	parameter int MAX_BUFFER_SAMPLES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample channel
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic signed [15:0]  pcm_sample,
	input  logic                end_of_buffer,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [15:0]  scaled_sample,
	output logic                level_valid,
	output logic [LEVEL_W-1:0]  rms_level,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int CNT_W = $clog2(MAX_BUFFER_SAMPLES + 1);

	logic [GAIN_W-1:0] gain_q;
	uword_t            uw;
	dp_status_t        status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GAIN) ? 32'(gain_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAIN) begin
			gain_q <= pwdata[GAIN_W-1:0];
		end
	end

	assign sample_stall = (uw.op != OP_LATCH);

	gcrm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uw     (uw)
	);

	gcrm_datapath #(
		.CNT_W       (CNT_W),
		.MAX_SAMPLES (MAX_BUFFER_SAMPLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.uw            (uw),
		.gain          (gain_q),
		.sample_valid  (sample_valid),
		.pcm_sample    (pcm_sample),
		.end_of_buffer (end_of_buffer),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.scaled_sample (scaled_sample),
		.level_valid   (level_valid),
		.rms_level     (rms_level),
		.status        (status)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/gcrm_checker.sv
// ---------------------------------------------------------------------------
// gcrm_checker
// Port-level checks on the gain clamp RMS meter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gain_clamp_rms_meter_defines.svh"

module gcrm_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        sample_valid,
	input  wire        sample_stall,
	input  wire        result_valid,
	input  wire        result_stall,
	input  wire [15:0] scaled_sample,
	input  wire        level_valid,
	input  wire [14:0] rms_level
);

	// one word in flight: an accepted word always stalls the next cycle
	`GCRM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, sample_valid && !sample_stall, sample_stall)

	// level is zero on words without the end-of-buffer flag
	`GCRM_ASSERT_NOW(a_level_zero, clk, arst_n, result_valid && !level_valid, rms_level == 15'd0)

	`GCRM_ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && result_stall, result_valid)

	`GCRM_ASSERT_NEXT(a_out_stable, clk, arst_n, result_valid && result_stall, $stable(scaled_sample) && $stable(level_valid) && $stable(rms_level))

endmodule

bind gain_clamp_rms_meter gcrm_checker u_gcrm_checker (.*);

`default_nettype wire
